@@ rtl/rlsv_pkg.sv @@
// Package for the retry-limited secret vault: table size, status codes,
// request and result structs, secret length clamp and byte mask helpers.
// No dependencies.
package rlsv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int ID_W    = 64;
   localparam int SEC_W   = 64;
   localparam int LEN_W   = 4;
   localparam int REC_W   = 64;
   localparam int CNT_W   = 16;
   localparam int STAT_W  = 3;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

   typedef enum logic {
      REQ_ENROLL = 1'b0,
      REQ_OPEN   = 1'b1
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_ALREADY  = 3'd1,
      ST_NOT_REG  = 3'd2,
      ST_NO_GUESS = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [ID_W-1:0]    key_id;
      logic [SEC_W-1:0]   secret;
      logic [LEN_W-1:0]   secret_len;
      logic [REC_W-1:0]   recovery;
      logic [CNT_W-1:0]   limit;
   } request_type;

   typedef struct packed {
      status_type         status;
      logic               correct;
      logic [REC_W-1:0]   recovery;
      logic [CNT_W-1:0]   left;
   } result_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

   // Keeps the low len bytes; len is already clamped to 0..8.
   function automatic logic [SEC_W-1:0] mask_secret(input logic [SEC_W-1:0] sec,
                                                    input logic [LEN_W-1:0] len);
      logic [SEC_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < SEC_W / 8; b++) begin
         if (LEN_W'(b) < len) begin
            mask[b*8 +: 8] = 8'hFF;
         end
      end
      return sec & mask;
   endfunction

endpackage

@@ rtl/rlsv_table.sv @@
// Vault entry table: identifier match, free entry search, secret compare
// and guess counter update for one transaction per cycle.
// Depends on rlsv_pkg.
module rlsv_table import rlsv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  request_type req,
   output result_type  res
);

   logic [ENTRIES-1:0] entry_valid_ff;
   logic [ENTRIES-1:0] entry_valid_in;
   logic [ID_W-1:0]    entry_id_ff       [ENTRIES];
   logic [SEC_W-1:0]   entry_secret_ff   [ENTRIES];
   logic [LEN_W-1:0]   entry_len_ff      [ENTRIES];
   logic [REC_W-1:0]   entry_recovery_ff [ENTRIES];
   logic [CNT_W-1:0]   entry_limit_ff    [ENTRIES];
   logic [CNT_W-1:0]   entry_left_ff     [ENTRIES];

   logic [LEN_W-1:0]   len;
   logic [SEC_W-1:0]   sec;
   logic [ENTRIES-1:0] hit;
   logic               hit_any;
   logic [IDX_W-1:0]   hit_idx;
   logic               free_any;
   logic [IDX_W-1:0]   free_idx;
   logic [CNT_W-1:0]   left_sel;
   logic               match;
   logic [CNT_W-1:0]   new_left;
   logic               do_enroll;
   logic               do_open;

   assign len = clamp_len(req.secret_len);
   assign sec = mask_secret(req.secret, len);

   always_comb begin
      hit      = '0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i] = entry_valid_ff[i] && (entry_id_ff[i] == req.key_id);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!entry_valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any  = |hit;
   assign free_any = ~&entry_valid_ff;
   assign left_sel = entry_left_ff[hit_idx];
   assign match    = (entry_secret_ff[hit_idx] == sec) && (entry_len_ff[hit_idx] == len);
   assign new_left = match ? entry_limit_ff[hit_idx] : left_sel - CNT_W'(1);

   assign do_enroll = go && (req.kind == REQ_ENROLL) && !hit_any && free_any;
   assign do_open   = go && (req.kind == REQ_OPEN) && hit_any && (left_sel != '0);

   always_comb begin
      res = '{status: ST_OK, correct: 1'b0, recovery: '0, left: '0};
      case (req.kind)
         REQ_ENROLL: begin
            if (hit_any) begin
               res.status = ST_ALREADY;
            end else if (!free_any) begin
               res.status = ST_FULL;
            end
         end
         REQ_OPEN: begin
            if (!hit_any) begin
               res.status = ST_NOT_REG;
            end else if (left_sel == '0) begin
               res.status = ST_NO_GUESS;
            end else begin
               res.correct  = match;
               res.recovery = match ? entry_recovery_ff[hit_idx] : '0;
               res.left     = new_left;
            end
         end
         default: begin
            res.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (do_enroll) begin
         entry_valid_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enroll) begin
         entry_id_ff[free_idx]       <= req.key_id;
         entry_secret_ff[free_idx]   <= sec;
         entry_len_ff[free_idx]      <= len;
         entry_recovery_ff[free_idx] <= req.recovery;
         entry_limit_ff[free_idx]    <= req.limit;
         entry_left_ff[free_idx]     <= req.limit;
      end else if (do_open) begin
         entry_left_ff[hit_idx]      <= new_left;
      end
   end

endmodule

@@ rtl/retry_limited_secret_vault_unit.sv @@
// Channel    | Direction | Handshake             | Payload
// req_       | in        | req_valid / req_ready | type, id, secret, length, recovery, limit
// rsp_       | out       | rsp_valid / rsp_ready | status, guess_correct, recovery, guesses_left
//
// One transaction per cycle sustained while rsp_ready is high: each request is held in
// the input register, then its lookup, compare and counter update resolve combinationally
// into the result register, which loads when the input register advances.
// Synchronous active-high reset empties both registers and clears all valid bits.
// A stalled result holds the input register; req_ready drops only while both are full.
// Depends on rlsv_pkg and rlsv_table.
module retry_limited_secret_vault_unit import rlsv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [ID_W-1:0]    req_key_id,
   input  logic [SEC_W-1:0]   req_secret,
   input  logic [LEN_W-1:0]   req_secret_len,
   input  logic [REC_W-1:0]   req_recovery_value,
   input  logic [CNT_W-1:0]   req_guess_limit,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic               rsp_guess_correct,
   output logic [REC_W-1:0]   rsp_recovery_out,
   output logic [CNT_W-1:0]   rsp_guesses_left
);

   logic        s1_valid_ff;
   logic        s1_valid_in;
   request_type s1_req_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_res_ff;
   result_type  res;
   logic        advance;
   logic        req_fire;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);

   rlsv_table u_table (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .req   (s1_req_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= '{kind:       req_kind_type'(req_type),
                        key_id:     req_key_id,
                        secret:     req_secret,
                        secret_len: req_secret_len,
                        recovery:   req_recovery_value,
                        limit:      req_guess_limit};
      end
      if (advance) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_res_ff.status;
   assign rsp_guess_correct = rsp_res_ff.correct;
   assign rsp_recovery_out  = rsp_res_ff.recovery;
   assign rsp_guesses_left  = rsp_res_ff.left;

`ifndef ASSERT_OFF
   a_correct_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_res_ff.correct |-> rsp_res_ff.status == ST_OK)
      else $error("guess_correct with non-ok status");

   a_recovery_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_res_ff.correct |-> rsp_res_ff.recovery == '0)
      else $error("recovery key leaked on failed guess");

   a_left_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_res_ff.status != ST_OK |-> rsp_res_ff.left == '0)
      else $error("guesses_left nonzero on refused transaction");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("input stage lost a stalled transaction");
`endif

endmodule
